### rtl/bmsi_pkg.sv
// Shared types, codes and constants of the bank mapper with scanline interrupt.
package bmsi_pkg;

    localparam int PRG_BANK_BITS = 6;
    localparam int CNT_W         = 6;
    localparam int ADDR_W        = 19;
    localparam int BUS_ADDR_W    = 16;
    localparam int DATA_W        = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 6;
    // Width for twice the chunk count, wide enough for the bank modulus.
    localparam int DBL_W         = (PRG_BANK_BITS > CNT_W + 1) ? PRG_BANK_BITS : CNT_W + 1;

    localparam logic [CNT_W-1:0]     PRG_COUNT_RESET = CNT_W'(2);
    localparam logic [BUS_ADDR_W-1:0] PRG_RAM_BASE   = 16'h6000;
    localparam logic [BUS_ADDR_W-1:0] PRG_RAM_TOP    = 16'h7FFF;

    typedef logic [PRG_BANK_BITS-1:0] prg_bank_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
    typedef logic [BUS_ADDR_W-1:0]    bus_address_t;
    typedef logic [DATA_W-1:0]        byte_t;
    typedef logic [ADDR_W-1:0]        mapped_address_t;

    typedef enum logic [2:0] {
        KIND_CPU_READ  = 3'd0,
        KIND_CPU_WRITE = 3'd1,
        KIND_PPU_READ  = 3'd2,
        KIND_PPU_WRITE = 3'd3,
        KIND_TICK      = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        TGT_NONE      = 3'd0,
        TGT_PRG_RAM   = 3'd1,
        TGT_PRG_ROM   = 3'd2,
        TGT_CHR       = 3'd3,
        TGT_NAMETABLE = 3'd4
    } target_t;

    // Register window decoded from CPU address bits 14:13 above 0x8000.
    typedef enum logic [1:0] {
        WIN_BANK   = 2'd0,
        WIN_MIRROR = 2'd1,
        WIN_IRQ    = 2'd2,
        WIN_ENABLE = 2'd3
    } reg_window_t;

    localparam cfg_index_t CFG_PRG_COUNT = 1'd0;
    localparam cfg_index_t CFG_CHR_RAM   = 1'd1;

    typedef struct packed {
        target_t         target;
        mapped_address_t mapped_address;
        logic            write_enable;
        byte_t           write_data;
        logic            irq_pulse;
    } result_t;

endpackage

### rtl/bmsi_if.sv
// Valid/ready channel interfaces for bus events in and mapping results out.
interface bmsi_in_if;
    import bmsi_pkg::*;

    logic         valid;
    logic         ready;
    logic [2:0]   kind;
    bus_address_t bus_address;
    byte_t        bus_data;

    modport source (output valid, output kind, output bus_address, output bus_data,
                    input ready);
    modport sink (input valid, input kind, input bus_address, input bus_data,
                  output ready);
endinterface

interface bmsi_out_if;
    import bmsi_pkg::*;

    logic            valid;
    logic            ready;
    logic [2:0]      target;
    mapped_address_t mapped_address;
    logic            write_enable;
    byte_t           write_data;
    logic            irq_pulse;

    modport source (output valid, output target, output mapped_address,
                    output write_enable, output write_data, output irq_pulse,
                    input ready);
    modport sink (input valid, input target, input mapped_address,
                  input write_enable, input write_data, input irq_pulse,
                  output ready);
endinterface

### rtl/bmsi_core.sv
// Mapper state, register programming, address translation and scanline counter.
module bmsi_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [2:0]               kind,
    input  bmsi_pkg::bus_address_t   bus_address,
    input  bmsi_pkg::byte_t          bus_data,
    input  logic                     cfg_we,
    input  bmsi_pkg::cfg_index_t     cfg_index,
    input  bmsi_pkg::cfg_data_t      cfg_data,
    output bmsi_pkg::result_t        result
);
    import bmsi_pkg::*;

    logic [CNT_W-1:0] prg_count_reg;
    logic             chr_is_ram_reg;
    logic [2:0]       bank_select_reg, bank_select_next;
    logic             prg_swap_mode_reg, prg_swap_mode_next;
    logic             chr_invert_reg, chr_invert_next;
    byte_t            bank_regs_reg [8];
    byte_t            bank_regs_next [8];
    logic             maps_valid_reg, maps_valid_next;
    logic             mirror_horizontal_reg, mirror_horizontal_next;
    byte_t            irq_reload_value_reg, irq_reload_value_next;
    byte_t            irq_count_reg, irq_count_next;
    logic             irq_on_reg, irq_on_next;
    logic             irq_reload_pending_reg, irq_reload_pending_next;

    logic [DBL_W-1:0] count_dbl;
    prg_bank_t        second_last_bank;
    prg_bank_t        last_bank;
    prg_bank_t        r6_bank;
    prg_bank_t        prg_bank;
    logic [2:0]       chr_slot;
    byte_t            chr_bank;
    logic [13:0]      pa;
    logic [10:0]      nt_address;
    logic             in_prg_ram;

    assign count_dbl        = DBL_W'({prg_count_reg, 1'b0});
    assign second_last_bank = PRG_BANK_BITS'(count_dbl - DBL_W'(2));
    assign last_bank        = PRG_BANK_BITS'(count_dbl - DBL_W'(1));
    assign r6_bank          = bank_regs_reg[6][PRG_BANK_BITS-1:0];
    assign pa               = bus_address[13:0];
    assign in_prg_ram       = bus_address inside {[PRG_RAM_BASE:PRG_RAM_TOP]};
    assign nt_address       = {mirror_horizontal_reg ? pa[11] : pa[10], pa[9:0]};

    // Bank maps are derived from the bank registers; before the first bank
    // write they keep their power-on contents.
    always_comb
    begin
        case (bus_address[14:13])
            2'd0:    prg_bank = !maps_valid_reg ? '0
                              : (prg_swap_mode_reg ? second_last_bank : r6_bank);
            2'd1:    prg_bank = maps_valid_reg ? bank_regs_reg[7][PRG_BANK_BITS-1:0]
                                               : PRG_BANK_BITS'(1);
            2'd2:    prg_bank = (maps_valid_reg && prg_swap_mode_reg) ? r6_bank
                                                                      : second_last_bank;
            default: prg_bank = last_bank;
        endcase
    end

    // With CHR inversion the 2 KiB pair banks move to the upper half.
    assign chr_slot = pa[12:10] ^ {chr_invert_reg, 2'b00};

    always_comb
    begin
        case (chr_slot)
            3'd0, 3'd1: chr_bank = {bank_regs_reg[0][7:1], chr_slot[0]};
            3'd2, 3'd3: chr_bank = {bank_regs_reg[1][7:1], chr_slot[0]};
            3'd4:       chr_bank = bank_regs_reg[2];
            3'd5:       chr_bank = bank_regs_reg[3];
            3'd6:       chr_bank = bank_regs_reg[4];
            default:    chr_bank = bank_regs_reg[5];
        endcase
        if (!maps_valid_reg)
        begin
            chr_bank = '0;
        end
    end

    always_comb
    begin
        result                  = '0;
        result.target           = TGT_NONE;
        bank_select_next        = bank_select_reg;
        prg_swap_mode_next      = prg_swap_mode_reg;
        chr_invert_next         = chr_invert_reg;
        bank_regs_next          = bank_regs_reg;
        maps_valid_next         = maps_valid_reg;
        mirror_horizontal_next  = mirror_horizontal_reg;
        irq_reload_value_next   = irq_reload_value_reg;
        irq_count_next          = irq_count_reg;
        irq_on_next             = irq_on_reg;
        irq_reload_pending_next = irq_reload_pending_reg;

        case (kind_t'(kind))
            KIND_CPU_READ:
            begin
                if (in_prg_ram)
                begin
                    result.target         = TGT_PRG_RAM;
                    result.mapped_address = ADDR_W'(bus_address[12:0]);
                end
                else if (bus_address[15])
                begin
                    result.target         = TGT_PRG_ROM;
                    result.mapped_address = ADDR_W'({prg_bank, bus_address[12:0]});
                end
                else
                begin
                    result.target         = TGT_PRG_ROM;
                    result.mapped_address = ADDR_W'(bus_address[12:0]);
                end
            end
            KIND_CPU_WRITE:
            begin
                result.write_data = bus_data;
                if (in_prg_ram)
                begin
                    result.target         = TGT_PRG_RAM;
                    result.mapped_address = ADDR_W'(bus_address[12:0]);
                    result.write_enable   = 1'b1;
                end
                else if (bus_address[15])
                begin
                    case (reg_window_t'(bus_address[14:13]))
                        WIN_BANK:
                        begin
                            if (!bus_address[0])
                            begin
                                bank_select_next   = bus_data[2:0];
                                prg_swap_mode_next = bus_data[6];
                                chr_invert_next    = bus_data[7];
                            end
                            else
                            begin
                                bank_regs_next[bank_select_reg] = bus_data;
                            end
                            maps_valid_next = 1'b1;
                        end
                        WIN_MIRROR:
                        begin
                            if (!bus_address[0])
                            begin
                                mirror_horizontal_next = bus_data[0];
                            end
                        end
                        WIN_IRQ:
                        begin
                            if (!bus_address[0])
                            begin
                                irq_reload_value_next = bus_data;
                            end
                            else
                            begin
                                irq_count_next          = '0;
                                irq_reload_pending_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            irq_on_next = bus_address[0];
                        end
                    endcase
                end
            end
            KIND_PPU_READ:
            begin
                if (pa[13])
                begin
                    result.target         = TGT_NAMETABLE;
                    result.mapped_address = ADDR_W'(nt_address);
                end
                else
                begin
                    result.target         = TGT_CHR;
                    result.mapped_address = ADDR_W'({chr_bank, pa[9:0]});
                end
            end
            KIND_PPU_WRITE:
            begin
                result.write_data = bus_data;
                if (pa[13])
                begin
                    result.target         = TGT_NAMETABLE;
                    result.mapped_address = ADDR_W'(nt_address);
                    result.write_enable   = 1'b1;
                end
                else if (chr_is_ram_reg)
                begin
                    result.target         = TGT_CHR;
                    result.mapped_address = ADDR_W'(pa[12:0]);
                    result.write_enable   = 1'b1;
                end
            end
            KIND_TICK:
            begin
                if ((irq_count_reg == '0) || irq_reload_pending_reg)
                begin
                    irq_count_next          = irq_reload_value_reg;
                    irq_reload_pending_next = 1'b0;
                end
                else
                begin
                    irq_count_next = irq_count_reg - 8'd1;
                end
                result.irq_pulse = (irq_count_next == '0) && irq_on_reg;
            end
            default:
            begin
                result.target = TGT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg          <= PRG_COUNT_RESET;
            chr_is_ram_reg         <= 1'b0;
            bank_select_reg        <= '0;
            prg_swap_mode_reg      <= 1'b0;
            chr_invert_reg         <= 1'b0;
            bank_regs_reg          <= '{default: '0};
            maps_valid_reg         <= 1'b0;
            mirror_horizontal_reg  <= 1'b0;
            irq_reload_value_reg   <= '0;
            irq_count_reg          <= '0;
            irq_on_reg             <= 1'b0;
            irq_reload_pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRG_COUNT: prg_count_reg  <= cfg_data[CNT_W-1:0];
                    CFG_CHR_RAM:   chr_is_ram_reg <= cfg_data[0];
                    default:       chr_is_ram_reg <= chr_is_ram_reg;
                endcase
            end
            if (accept)
            begin
                bank_select_reg        <= bank_select_next;
                prg_swap_mode_reg      <= prg_swap_mode_next;
                chr_invert_reg         <= chr_invert_next;
                bank_regs_reg          <= bank_regs_next;
                maps_valid_reg         <= maps_valid_next;
                mirror_horizontal_reg  <= mirror_horizontal_next;
                irq_reload_value_reg   <= irq_reload_value_next;
                irq_count_reg          <= irq_count_next;
                irq_on_reg             <= irq_on_next;
                irq_reload_pending_reg <= irq_reload_pending_next;
            end
        end
    end

endmodule

### rtl/bank_mapper_scanline_irq_unit.sv
// Top level of the cartridge bank mapper with scanline interrupt counter.
// The unit takes one bus event word per clock while its input is ready
// (CPU read or write, PPU read or write, or scanline tick) and returns one
// result word for each: the memory that must answer, the byte address inside
// it, a write strobe with its data, and an interrupt pulse for ticks that fire
// the counter. Each word is mapped in a single pass of logic against the
// current mapper state and is registered once accepted, so the sustained
// rate is one word per clock for as long as the result side takes words. A
// second output entry acts as a skid stage: the input stays ready while a
// result waits, and drops ready only when both entries hold words.
// CPU writes at 0x8000 and above program the mapper and return a result
// with no target. The PRG chunk count and the CHR RAM flag are set through
// the configuration port, which must only be written while the unit is idle.
module bank_mapper_scanline_irq_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    bmsi_in_if.sink              access,
    bmsi_out_if.source           result,
    input  logic                 cfg_we,
    input  bmsi_pkg::cfg_index_t cfg_index,
    input  bmsi_pkg::cfg_data_t  cfg_data
);
    import bmsi_pkg::*;

    logic    accept;
    logic    out_free;
    result_t mapped;
    result_t out_word_reg;
    logic    out_valid_reg;
    result_t skid_word_reg;
    logic    skid_valid_reg;

    // The skid entry only fills when the output register is stalled, so the
    // input can be ready from a register alone.
    assign access.ready = !skid_valid_reg;
    assign accept       = access.valid && !skid_valid_reg;
    assign out_free     = !out_valid_reg || result.ready;

    bmsi_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (access.kind),
        .bus_address (access.bus_address),
        .bus_data    (access.bus_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .result      (mapped)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                // The skid entry is older than any new word, so it goes first.
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : mapped;
        end
        else if (accept)
        begin
            skid_word_reg <= mapped;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.target         = out_word_reg.target;
    assign result.mapped_address = out_word_reg.mapped_address;
    assign result.write_enable   = out_word_reg.write_enable;
    assign result.write_data     = out_word_reg.write_data;
    assign result.irq_pulse      = out_word_reg.irq_pulse;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the cartridge bank mapper with scanline interrupt counter.
module testbench;
    import bmsi_pkg::*;

    // Idle cycles with no word moved on any port before the run is declared hung.
    localparam int unsigned HANG_LIMIT     = 2000;
    // Random words sent under each configuration setting.
    localparam int unsigned WORDS_PER_PASS = 225;
    localparam int unsigned SETTING_PASSES = 8;
    localparam int unsigned DIRECTED_ROWS  = 26;

    typedef struct {
        kind_t        kind;
        bus_address_t addr;
        byte_t        data;
        bit           typed;
        result_t      want;
    } access_row_t;

    localparam result_t UNTYPED = '0;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    bmsi_in_if  acc ();
    bmsi_out_if res ();

    bank_mapper_scanline_irq_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .access    (acc),
        .result    (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the mapper state, kept in step with every accepted word
    // and every configuration write.
    logic [CNT_W-1:0] prg_count;
    logic             chr_ram;
    logic [2:0]       sel_reg;
    logic             prg_swap;
    logic             chr_swap;
    byte_t            bank_data [8];
    byte_t            chr_page [8];
    prg_bank_t        prg_page [3];
    logic             mirror_h;
    byte_t            line_preset;
    byte_t            line_count;
    logic             irq_armed;
    logic             preset_due;

    // Results still owed by the unit, oldest first.
    result_t          owed_results [$];

    int unsigned      mismatches;
    int unsigned      result_index;
    int unsigned      sent_words;
    int unsigned      idle_cycles;
    // While set, neither the sender nor the receiver starts a new idle stretch.
    bit               steady;

    // The directed words. Rows with typed set carry an expectation that can be
    // read straight off the reset state; the others are left to the predictor.
    access_row_t directed_rows [DIRECTED_ROWS] = '{
        // CPU reads below 0x6000 land in PRG ROM bank 0.
        '{KIND_CPU_READ,  16'h0000, 8'h00, 1'b1, '{TGT_PRG_ROM,   19'h00000, 1'b0, 8'h00, 1'b0}},
        '{KIND_CPU_READ,  16'h5FFF, 8'hFF, 1'b1, '{TGT_PRG_ROM,   19'h01FFF, 1'b0, 8'h00, 1'b0}},
        // Both ends of the PRG RAM window.
        '{KIND_CPU_READ,  16'h6000, 8'h00, 1'b1, '{TGT_PRG_RAM,   19'h00000, 1'b0, 8'h00, 1'b0}},
        '{KIND_CPU_WRITE, 16'h7FFF, 8'hFF, 1'b1, '{TGT_PRG_RAM,   19'h01FFF, 1'b1, 8'hFF, 1'b0}},
        // A CPU write below 0x6000 goes nowhere but still echoes its data.
        '{KIND_CPU_WRITE, 16'h0000, 8'hA5, 1'b1, '{TGT_NONE,      19'h00000, 1'b0, 8'hA5, 1'b0}},
        // The four PRG windows at reset: banks 0, 1, 2 and 3 with two chunks.
        '{KIND_CPU_READ,  16'h8000, 8'h00, 1'b1, '{TGT_PRG_ROM,   19'h00000, 1'b0, 8'h00, 1'b0}},
        '{KIND_CPU_READ,  16'hA000, 8'h00, 1'b1, '{TGT_PRG_ROM,   19'h02000, 1'b0, 8'h00, 1'b0}},
        '{KIND_CPU_READ,  16'hC000, 8'h00, 1'b1, '{TGT_PRG_ROM,   19'h04000, 1'b0, 8'h00, 1'b0}},
        '{KIND_CPU_READ,  16'hFFFF, 8'h00, 1'b1, '{TGT_PRG_ROM,   19'h07FFF, 1'b0, 8'h00, 1'b0}},
        // PPU pattern and nametable space with vertical mirroring.
        '{KIND_PPU_READ,  16'h0000, 8'h00, 1'b1, '{TGT_CHR,       19'h00000, 1'b0, 8'h00, 1'b0}},
        '{KIND_PPU_READ,  16'h3FFF, 8'h00, 1'b1, '{TGT_NAMETABLE, 19'h007FF, 1'b0, 8'h00, 1'b0}},
        '{KIND_PPU_WRITE, 16'h2400, 8'h5A, 1'b1, '{TGT_NAMETABLE, 19'h00400, 1'b1, 8'h5A, 1'b0}},
        // CHR is ROM after reset, so a pattern write is dropped.
        '{KIND_PPU_WRITE, 16'h1FFF, 8'h11, 1'b1, '{TGT_NONE,      19'h00000, 1'b0, 8'h11, 1'b0}},
        // A tick ignores address and data; interrupts are still off.
        '{KIND_TICK,      16'hFFFF, 8'hFF, 1'b1, '{TGT_NONE,      19'h00000, 1'b0, 8'h00, 1'b0}},
        // Enable interrupts; a zero latch makes the next tick fire.
        '{KIND_CPU_WRITE, 16'hE001, 8'h00, 1'b1, '{TGT_NONE,      19'h00000, 1'b0, 8'h00, 1'b0}},
        '{KIND_TICK,      16'h0000, 8'h00, 1'b1, '{TGT_NONE,      19'h00000, 1'b0, 8'h00, 1'b1}},
        // Select register 7 with PRG swap and CHR inversion, then load it.
        '{KIND_CPU_WRITE, 16'h8000, 8'hC7, 1'b0, UNTYPED},
        '{KIND_CPU_WRITE, 16'h8001, 8'hFF, 1'b0, UNTYPED},
        '{KIND_CPU_READ,  16'h8000, 8'h00, 1'b0, UNTYPED},
        '{KIND_PPU_READ,  16'h1C00, 8'h00, 1'b0, UNTYPED},
        // Horizontal mirroring picks address bit 11 for the nametable.
        '{KIND_CPU_WRITE, 16'hA000, 8'h01, 1'b0, UNTYPED},
        '{KIND_PPU_READ,  16'h2800, 8'h00, 1'b0, UNTYPED},
        // The PRG RAM protect register is accepted and ignored.
        '{KIND_CPU_WRITE, 16'hA001, 8'hFF, 1'b0, UNTYPED},
        // Latch 1 and request a reload: the tick reloads the counter and does not fire.
        '{KIND_CPU_WRITE, 16'hC000, 8'h01, 1'b0, UNTYPED},
        '{KIND_CPU_WRITE, 16'hC001, 8'h00, 1'b0, UNTYPED},
        '{KIND_TICK,      16'h0000, 8'h00, 1'b0, UNTYPED}
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic prg_bank_t second_last_bank();
        return prg_bank_t'(int'(prg_count) * 2 - 2);
    endfunction

    function automatic prg_bank_t last_bank();
        return prg_bank_t'(int'(prg_count) * 2 - 1);
    endfunction

    task automatic clear_shadow();
        prg_count   = PRG_COUNT_RESET;
        chr_ram     = 1'b0;
        sel_reg     = '0;
        prg_swap    = 1'b0;
        chr_swap    = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            bank_data[i] = '0;
            chr_page[i]  = '0;
        end
        prg_page[0] = '0;
        prg_page[1] = prg_bank_t'(1);
        prg_page[2] = second_last_bank();
        mirror_h    = 1'b0;
        line_preset = '0;
        line_count  = '0;
        irq_armed   = 1'b0;
        preset_due  = 1'b0;
    endtask

    // Rebuilds the CHR and PRG page tables from the bank registers. The two
    // 2 KiB CHR registers drop their low bit and cover a pair of 1 KiB pages.
    function automatic void rebuild_pages();
        byte_t pair0;
        byte_t pair1;
        int    lo;
        int    hi;
        pair0 = bank_data[0] & 8'hFE;
        pair1 = bank_data[1] & 8'hFE;
        lo    = chr_swap ? 4 : 0;
        hi    = chr_swap ? 0 : 4;
        chr_page[lo]     = pair0;
        chr_page[lo + 1] = pair0 + 8'd1;
        chr_page[lo + 2] = pair1;
        chr_page[lo + 3] = pair1 + 8'd1;
        for (int i = 0; i < 4; i++)
            chr_page[hi + i] = bank_data[2 + i];
        prg_page[0] = prg_swap ? second_last_bank() : prg_bank_t'(bank_data[6]);
        prg_page[1] = prg_bank_t'(bank_data[7]);
        prg_page[2] = prg_swap ? prg_bank_t'(bank_data[6]) : second_last_bank();
    endfunction

    // Mapper register writes, decoded by window and by the low address bit.
    function automatic void program_register(bus_address_t a, byte_t d);
        case (reg_window_t'(a[14:13]))
            WIN_BANK:
            begin
                if (!a[0])
                begin
                    sel_reg  = d[2:0];
                    prg_swap = d[6];
                    chr_swap = d[7];
                end
                else
                begin
                    bank_data[sel_reg] = d;
                end
                rebuild_pages();
            end
            WIN_MIRROR:
            begin
                if (!a[0])
                    mirror_h = d[0];
            end
            WIN_IRQ:
            begin
                if (!a[0])
                begin
                    line_preset = d;
                end
                else
                begin
                    line_count = '0;
                    preset_due = 1'b1;
                end
            end
            WIN_ENABLE:
            begin
                irq_armed = a[0];
            end
        endcase
    endfunction

    function automatic mapped_address_t nametable_offset(logic [13:0] pa);
        return mapped_address_t'({mirror_h ? pa[11] : pa[10], pa[9:0]});
    endfunction

    // Maps one bus word against the shadow state and updates that state.
    function automatic result_t map_access(kind_t k, bus_address_t a, byte_t d);
        result_t     r;
        logic [13:0] pa;
        prg_bank_t   bank;
        r  = '0;
        pa = a[13:0];
        case (k)
            KIND_CPU_READ:
            begin
                r.target = TGT_PRG_ROM;
                if (a >= PRG_RAM_BASE && a <= PRG_RAM_TOP)
                begin
                    r.target         = TGT_PRG_RAM;
                    r.mapped_address = mapped_address_t'(a[12:0]);
                end
                else if (a[15])
                begin
                    bank = (a[14:13] == 2'd3) ? last_bank() : prg_page[a[14:13]];
                    r.mapped_address = {bank, a[12:0]};
                end
                else
                begin
                    r.mapped_address = mapped_address_t'(a[12:0]);
                end
            end
            KIND_CPU_WRITE:
            begin
                r.write_data = d;
                if (a >= PRG_RAM_BASE && a <= PRG_RAM_TOP)
                begin
                    r.target         = TGT_PRG_RAM;
                    r.mapped_address = mapped_address_t'(a[12:0]);
                    r.write_enable   = 1'b1;
                end
                else if (a[15])
                begin
                    program_register(a, d);
                end
            end
            KIND_PPU_READ:
            begin
                if (pa[13])
                begin
                    r.target         = TGT_NAMETABLE;
                    r.mapped_address = nametable_offset(pa);
                end
                else
                begin
                    r.target         = TGT_CHR;
                    r.mapped_address = mapped_address_t'({chr_page[pa[12:10]], pa[9:0]});
                end
            end
            KIND_PPU_WRITE:
            begin
                r.write_data = d;
                if (pa[13])
                begin
                    r.target         = TGT_NAMETABLE;
                    r.mapped_address = nametable_offset(pa);
                    r.write_enable   = 1'b1;
                end
                else if (chr_ram)
                begin
                    r.target         = TGT_CHR;
                    r.mapped_address = mapped_address_t'(pa[12:0]);
                    r.write_enable   = 1'b1;
                end
            end
            KIND_TICK:
            begin
                // An empty counter or a pending reload takes the latch;
                // otherwise the counter steps down by one.
                if (line_count == 8'd0 || preset_due)
                begin
                    line_count = line_preset;
                    preset_due = 1'b0;
                end
                else
                begin
                    line_count = line_count - 8'd1;
                end
                r.irq_pulse = (line_count == 8'd0) && irq_armed;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string text);
        mismatches++;
        $display("mismatch: %s", text);
    endtask

    // Presents one word on the access channel and holds it until taken. The
    // task is entered and left just after a falling edge; valid stays high on
    // exit so back-to-back words follow without a gap.
    task automatic push_word(input kind_t k, input bus_address_t a, input byte_t d,
                             input bit typed, input result_t want);
        int unsigned gap;
        result_t     guess;
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            acc.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        acc.valid       = 1'b1;
        acc.kind        = k;
        acc.bus_address = a;
        acc.bus_data    = d;
        do
            @(posedge clk);
        while (!acc.ready);
        // The word was taken at this edge: advance the shadow state now.
        guess = map_access(k, a, d);
        owed_results.push_back(typed ? want : guess);
        @(negedge clk);
    endtask

    task automatic send(input kind_t k, input bus_address_t a, input byte_t d);
        push_word(k, a, d, 1'b0, UNTYPED);
        sent_words++;
    endtask

    function automatic bus_address_t reg_address(reg_window_t w, bit odd);
        return {1'b1, w, 12'($urandom), odd};
    endfunction

    // Lowers valid and waits for the unit to hand back everything it owes.
    task automatic drain_results();
        acc.valid = 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
    endtask

    // Both registers are written back to back while the unit is idle; the
    // shadow copy changes at the same edge as the hardware.
    task automatic write_settings(input cfg_data_t count_val, input logic ram_val);
        cfg_we    = 1'b1;
        cfg_index = CFG_PRG_COUNT;
        cfg_data  = count_val;
        @(posedge clk);
        prg_count = count_val;
        prg_page[prg_swap ? 0 : 2] = second_last_bank();
        @(negedge clk);
        cfg_index = CFG_CHR_RAM;
        cfg_data  = cfg_data_t'(ram_val);
        @(posedge clk);
        chr_ram = ram_val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Random traffic: bank programming followed by fetches, interrupt setup
    // followed by scanlines, mirroring changes followed by nametable traffic,
    // and, most often, loose single words between.
    task automatic drive_random_traffic(input int unsigned words);
        int unsigned  stop_at;
        int unsigned  pick;
        int unsigned  ticks;
        kind_t        k;
        bus_address_t a;
        stop_at = sent_words + words;
        while (sent_words < stop_at)
        begin
            steady = ($urandom_range(0, 7) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 12)
            begin
                send(KIND_CPU_WRITE, reg_address(WIN_BANK, 1'b0), byte_t'($urandom));
                send(KIND_CPU_WRITE, reg_address(WIN_BANK, 1'b1), byte_t'($urandom));
                repeat (2)
                begin
                    a = bus_address_t'($urandom);
                    a[15] = 1'b1;
                    send(KIND_CPU_READ, a, byte_t'($urandom));
                end
                repeat (2)
                begin
                    a = bus_address_t'($urandom);
                    a[13] = 1'b0;
                    send(KIND_PPU_READ, a, byte_t'($urandom));
                end
            end
            else if (pick < 24)
            begin
                // Small latch values keep interrupts frequent.
                send(KIND_CPU_WRITE, reg_address(WIN_IRQ, 1'b0),
                     ($urandom_range(0, 3) == 0) ? byte_t'($urandom)
                                                 : byte_t'($urandom_range(0, 5)));
                send(KIND_CPU_WRITE, reg_address(WIN_IRQ, 1'b1), byte_t'($urandom));
                send(KIND_CPU_WRITE, reg_address(WIN_ENABLE, $urandom_range(0, 3) != 0),
                     byte_t'($urandom));
                ticks = $urandom_range(1, 10);
                repeat (ticks)
                    send(KIND_TICK, bus_address_t'($urandom), byte_t'($urandom));
            end
            else if (pick < 30)
            begin
                send(KIND_CPU_WRITE, reg_address(WIN_MIRROR, 1'b0), byte_t'($urandom));
                repeat (3)
                begin
                    a = bus_address_t'($urandom);
                    a[13] = 1'b1;
                    send($urandom_range(0, 1) ? KIND_PPU_READ : KIND_PPU_WRITE, a,
                         byte_t'($urandom));
                end
            end
            else
            begin
                k = kind_t'($urandom_range(0, 4));
                a = bus_address_t'($urandom);
                // Tilt CPU writes toward the register space above 0x8000.
                if (k == KIND_CPU_WRITE && $urandom_range(0, 1) == 1)
                    a[15] = 1'b1;
                send(k, a, byte_t'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    // Receiver: stalls of random length, mostly short and a few long; no new
    // stall begins while the sender is in a steady stretch.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        res.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res.ready = 1'b1;
                if (!steady && $urandom_range(0, 7) == 0)
                    stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    // Result checker: every word taken from the result channel is matched
    // field by field against the oldest owed result.
    initial
    begin
        result_t want;
        result_index = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    report_mismatch($sformatf("result word %0d arrived with none owed",
                                              result_index));
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (res.target !== want.target)
                        report_mismatch($sformatf("word %0d target 0x%0h, expected 0x%0h",
                                                  result_index, res.target, want.target));
                    if (res.mapped_address !== want.mapped_address)
                        report_mismatch($sformatf("word %0d address 0x%0h, expected 0x%0h",
                                                  result_index, res.mapped_address,
                                                  want.mapped_address));
                    if (res.write_enable !== want.write_enable)
                        report_mismatch($sformatf("word %0d write enable %0b, expected %0b",
                                                  result_index, res.write_enable,
                                                  want.write_enable));
                    if (res.write_data !== want.write_data)
                        report_mismatch($sformatf("word %0d write data 0x%0h, expected 0x%0h",
                                                  result_index, res.write_data,
                                                  want.write_data));
                    if (res.irq_pulse !== want.irq_pulse)
                        report_mismatch($sformatf("word %0d irq %0b, expected %0b",
                                                  result_index, res.irq_pulse, want.irq_pulse));
                end
                result_index++;
            end
        end
    end

    // Watchdog: any word moved on either channel, or a register write,
    // restarts the count of idle cycles.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((acc.valid && acc.ready) || (res.valid && res.ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Main sequence: reset, the directed words against the reset settings,
    // then passes of random traffic under changing settings. Each pass starts
    // with the sender held back until every owed result is in.
    initial
    begin
        cfg_data_t count_val;
        logic      ram_val;
        mismatches      = 0;
        sent_words      = 0;
        steady          = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_PRG_COUNT;
        cfg_data        = '0;
        acc.valid       = 1'b0;
        acc.kind        = KIND_CPU_READ;
        acc.bus_address = '0;
        acc.bus_data    = '0;
        clear_shadow();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            push_word(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);

        // The first passes pin both extremes of the chunk count with CHR as
        // RAM and as ROM; the rest pick settings at random.
        for (int pass = 0; pass < SETTING_PASSES; pass++)
        begin
            drain_results();
            case (pass)
                0:
                begin
                    count_val = 6'd1;
                    ram_val   = 1'b1;
                end
                1:
                begin
                    count_val = 6'd32;
                    ram_val   = 1'b0;
                end
                2:
                begin
                    count_val = 6'd32;
                    ram_val   = 1'b1;
                end
                3:
                begin
                    count_val = 6'd1;
                    ram_val   = 1'b0;
                end
                default:
                begin
                    count_val = cfg_data_t'($urandom_range(1, 32));
                    ram_val   = $urandom_range(0, 1);
                end
            endcase
            write_settings(count_val, ram_val);
            drive_random_traffic(WORDS_PER_PASS);
        end

        drain_results();
        // Keep the clock running after the drain so that any stray extra result is caught.
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### bank_mapper_scanline_irq_unit.f
rtl/bmsi_pkg.sv
rtl/bmsi_if.sv
rtl/bmsi_core.sv
rtl/bank_mapper_scanline_irq_unit.sv
tb/sv/testbench.sv
